### sv/dgr_pkg.sv
// ----------------------------------------------------------------------------
// dgr_pkg
// Shared types, constants and helpers of the distortion grid remap generator.
// ----------------------------------------------------------------------------
package dgr_pkg;

   localparam int GRID_SIZE           = 64;
   localparam int GRID_BITS           = $clog2(GRID_SIZE);
   localparam int MAX_DIMENSION       = 1024;
   localparam int DIM_BITS            = $clog2(MAX_DIMENSION);
   localparam int CFG_BITS            = DIM_BITS + 1;
   localparam int ENTRY_FRACTION_BITS = 16;
   localparam int ENTRY_BITS          = ENTRY_FRACTION_BITS + 2;
   localparam int COORD_FRACTION_BITS = 6;
   localparam int OUT_BITS            = 16;
   localparam int T_BITS              = 16;
   localparam int NUM_BITS            = DIM_BITS + GRID_BITS;
   localparam int QUOT_BITS           = GRID_BITS + T_BITS;
   localparam int BANK_ADDR_BITS      = 2 * (GRID_BITS - 1);
   localparam int BANK_DEPTH          = 1 << BANK_ADDR_BITS;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_PTR_BITS      = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } dgr_op_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } dgr_csr_type;

   // queue entry from front to back
   typedef struct packed {
      dgr_op_type                    op;
      logic [GRID_BITS-1:0]          row;
      logic [GRID_BITS-1:0]          col;
      logic signed [ENTRY_BITS-1:0]  ex;
      logic signed [ENTRY_BITS-1:0]  ey;
      logic [NUM_BITS-1:0]           num_x;
      logic [DIM_BITS-1:0]           den_x;
      logic [NUM_BITS-1:0]           num_y;
      logic [DIM_BITS-1:0]           den_y;
   } dgr_item_type;

   // part of an item that rides along the divider
   typedef struct packed {
      dgr_op_type                    op;
      logic [GRID_BITS-1:0]          row;
      logic [GRID_BITS-1:0]          col;
      logic signed [ENTRY_BITS-1:0]  ex;
      logic signed [ENTRY_BITS-1:0]  ey;
   } dgr_tag_type;

   typedef struct packed {
      logic empty;
      logic full;
   } dgr_queue_status_type;

   // clamped size minus one
   function automatic logic [DIM_BITS-1:0] size_m1(input logic [CFG_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v <= CFG_BITS'(1)) begin
         r = '0;
      end else if (v > CFG_BITS'(MAX_DIMENSION)) begin
         r = DIM_BITS'(MAX_DIMENSION - 1);
      end else begin
         r = DIM_BITS'(v - CFG_BITS'(1));
      end
      return r;
   endfunction

endpackage

### sv/dgr_front.sv
// ----------------------------------------------------------------------------
// dgr_front
// Takes request items, clamps the pixel and forms the dividends, and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module dgr_front
   import dgr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [GRID_BITS-1:0]         req_grid_row,
   input  logic [GRID_BITS-1:0]         req_grid_col,
   input  logic signed [ENTRY_BITS-1:0] req_entry_x,
   input  logic signed [ENTRY_BITS-1:0] req_entry_y,
   input  logic [DIM_BITS-1:0]          req_pixel_x,
   input  logic [DIM_BITS-1:0]          req_pixel_y,
   input  logic [DIM_BITS-1:0]          width_m1,
   input  logic [DIM_BITS-1:0]          height_m1,
   input  logic                         pop,
   output dgr_item_type                 head,
   output dgr_queue_status_type         status
);

   dgr_item_type              queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      push;
   logic [DIM_BITS-1:0]       px_clamped, py_clamped, pos_y;
   dgr_item_type              item;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign req_ready    = !status.full;
   assign push         = req_valid && req_ready;
   assign head         = queue_ff[rd_ptr_ff];

   always_comb begin
      px_clamped = (req_pixel_x > width_m1) ? width_m1 : req_pixel_x;
      py_clamped = (req_pixel_y > height_m1) ? height_m1 : req_pixel_y;
      pos_y      = height_m1 - py_clamped;
      item.op    = dgr_op_type'(req_opcode);
      item.row   = req_grid_row;
      item.col   = req_grid_col;
      item.ex    = req_entry_x;
      item.ey    = req_entry_y;
      item.num_x = NUM_BITS'(GRID_SIZE - 1) * NUM_BITS'(px_clamped);
      item.den_x = width_m1;
      item.num_y = NUM_BITS'(GRID_SIZE - 2) * NUM_BITS'(pos_y);
      item.den_y = height_m1;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### sv/dgr_divider.sv
// ----------------------------------------------------------------------------
// dgr_divider
// Pipelined restoring divider: (num << T_BITS) / den, one quotient bit per
// stage. The quotient must stay below 2^QUOT_BITS.
// ----------------------------------------------------------------------------
module dgr_divider
   import dgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  enable,
   input  logic [NUM_BITS-1:0]   num,
   input  logic [DIM_BITS-1:0]   den,
   output logic [QUOT_BITS-1:0]  quot
);

   logic [DIM_BITS-1:0]  rem_ff  [QUOT_BITS];
   logic [DIM_BITS-1:0]  rem_in  [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_in [QUOT_BITS];
   logic [GRID_BITS-1:0] low_ff  [QUOT_BITS];
   logic [GRID_BITS-1:0] low_in  [QUOT_BITS];
   logic [DIM_BITS-1:0]  den_ff  [QUOT_BITS];

   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_stage
      logic [DIM_BITS-1:0]  rem_src;
      logic [QUOT_BITS-1:0] quot_src;
      logic [GRID_BITS-1:0] low_src;
      logic [DIM_BITS-1:0]  den_src;
      logic [DIM_BITS:0]    trial;
      logic [DIM_BITS:0]    diff;
      logic                 take;

      if (i == 0) begin : g_first
         // upper dividend bits already lie below den
         assign rem_src  = num[NUM_BITS-1:GRID_BITS];
         assign quot_src = '0;
         assign low_src  = num[GRID_BITS-1:0];
         assign den_src  = den;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign quot_src = quot_ff[i-1];
         assign low_src  = low_ff[i-1];
         assign den_src  = den_ff[i-1];
      end

      assign trial      = {rem_src, low_src[GRID_BITS-1]};
      assign diff       = trial - {1'b0, den_src};
      assign take       = (trial >= {1'b0, den_src});
      assign rem_in[i]  = take ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
      assign quot_in[i] = {quot_src[QUOT_BITS-2:0], take};
      assign low_in[i]  = {low_src[GRID_BITS-2:0], 1'b0};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in[i];
            quot_ff[i] <= quot_in[i];
            low_ff[i]  <= low_in[i];
            den_ff[i]  <= den_src;
         end
      end
   end

   assign quot = quot_ff[QUOT_BITS-1];

endmodule

### sv/dgr_back.sv
// ----------------------------------------------------------------------------
// dgr_back
// Divides out cell and fraction, reads the four neighbours from a banked
// grid memory, interpolates and scales the result into the output register.
// ----------------------------------------------------------------------------
module dgr_back
   import dgr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dgr_item_type        head,
   input  dgr_queue_status_type status,
   output logic                pop,
   input  logic [DIM_BITS-1:0] width_m1,
   input  logic [DIM_BITS-1:0] height_m1,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_BITS-1:0] rsp_source_x,
   output logic [OUT_BITS-1:0] rsp_source_y,
   output logic                rsp_coord_valid
);

   localparam int A_BITS   = ENTRY_BITS + T_BITS + 1;
   localparam int S_BITS   = ENTRY_BITS + 2 * T_BITS + 1;
   localparam int ONE_POS  = ENTRY_FRACTION_BITS + 2 * T_BITS;
   localparam int D_BITS   = 2 * T_BITS + 1;
   localparam int P_BITS   = D_BITS + DIM_BITS;
   localparam int V_BITS   = P_BITS - (2 * T_BITS - COORD_FRACTION_BITS);
   localparam logic [S_BITS-1:0] S_ONE = S_BITS'(1) << ONE_POS;
   localparam logic [T_BITS:0]   W_ONE = (T_BITS+1)'(1) << T_BITS;

   logic advance;

   // ---------------- divider section
   dgr_tag_type          pipe_ff [QUOT_BITS];
   logic                 vld_ff  [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_x, quot_y;

   assign pop = advance && !status.empty;

   dgr_divider u_div_x (
      .clock  (clock),
      .enable (advance),
      .num    (head.num_x),
      .den    (head.den_x),
      .quot   (quot_x)
   );

   dgr_divider u_div_y (
      .clock  (clock),
      .enable (advance),
      .num    (head.num_y),
      .den    (head.den_y),
      .quot   (quot_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUOT_BITS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= !status.empty;
         for (int i = 1; i < QUOT_BITS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= '{op: head.op, row: head.row, col: head.col,
                         ex: head.ex, ey: head.ey};
         for (int i = 1; i < QUOT_BITS; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   // ---------------- cell split and memory access
   dgr_tag_type          tag;
   logic [GRID_BITS-1:0] x1, y1, x1_inc, y1_inc;
   logic [T_BITS-1:0]    tx, ty;
   logic                 load_we;
   logic [1:0]           wr_bank;
   logic [BANK_ADDR_BITS-1:0] wr_addr;
   logic [BANK_ADDR_BITS-1:0] rd_addr [4];

   assign tag = pipe_ff[QUOT_BITS-1];

   always_comb begin
      // a size of one leaves the axis at its far cell with no fraction
      if (width_m1 == '0) begin
         x1 = GRID_BITS'(GRID_SIZE - 1);
         tx = '0;
      end else begin
         x1 = quot_x[QUOT_BITS-1:T_BITS];
         tx = quot_x[T_BITS-1:0];
      end
      if (height_m1 == '0) begin
         y1 = GRID_BITS'(GRID_SIZE - 2);
         ty = '0;
      end else begin
         y1 = quot_y[QUOT_BITS-1:T_BITS];
         ty = quot_y[T_BITS-1:0];
      end
      x1_inc  = x1 + 1'b1;
      y1_inc  = y1 + 1'b1;
      load_we = vld_ff[QUOT_BITS-1] && (tag.op == OP_LOAD);
      wr_bank = {tag.row[0], tag.col[0]};
      wr_addr = {tag.row[GRID_BITS-1:1], tag.col[GRID_BITS-1:1]};
      // banks by row and column parity: even half takes the incremented cell
      for (int b = 0; b < 4; b++) begin
         rd_addr[b] = {(b[1] ? y1[GRID_BITS-1:1] : y1_inc[GRID_BITS-1:1]),
                       (b[0] ? x1[GRID_BITS-1:1] : x1_inc[GRID_BITS-1:1])};
      end
   end

   logic [2*ENTRY_BITS-1:0] rd_ff [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [2*ENTRY_BITS-1:0] mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (advance) begin
            if (load_we && (wr_bank == 2'(b))) begin
               mem[wr_addr] <= {tag.ey, tag.ex};
            end
            rd_ff[b] <= mem[rd_addr[b]];
         end
      end
   end

   logic              r_vld_ff;
   dgr_op_type        r_op_ff;
   logic [T_BITS-1:0] r_tx_ff, r_ty_ff;
   logic              r_xp_ff, r_yp_ff, r_dupx_ff, r_dupy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (advance) begin
         r_vld_ff <= vld_ff[QUOT_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_op_ff   <= tag.op;
         r_tx_ff   <= tx;
         r_ty_ff   <= ty;
         r_xp_ff   <= x1[0];
         r_yp_ff   <= y1[0];
         r_dupx_ff <= (x1 == GRID_BITS'(GRID_SIZE - 1));
         r_dupy_ff <= (y1 == GRID_BITS'(GRID_SIZE - 1));
      end
   end

   // ---------------- interpolation along x
   logic [2*ENTRY_BITS-1:0]      nb [4];
   logic signed [T_BITS+1:0]     wx0, wx1, wy0, wy1;
   logic signed [A_BITS-1:0]     ax_top_in, ax_bot_in, ay_top_in, ay_bot_in;
   logic signed [A_BITS:0]       sum_tmp [4];

   function automatic logic signed [A_BITS:0] lerp(
      input logic signed [ENTRY_BITS-1:0] e0,
      input logic signed [ENTRY_BITS-1:0] e1,
      input logic signed [T_BITS+1:0]     w0,
      input logic signed [T_BITS+1:0]     w1
   );
      logic signed [A_BITS:0] p0, p1;
      p0 = e0 * w0;
      p1 = e1 * w1;
      return p0 + p1;
   endfunction

   always_comb begin
      // neighbour order: (x1,y1) (x2,y1) (x1,y2) (x2,y2)
      nb[0] = rd_ff[{r_yp_ff, r_xp_ff}];
      nb[1] = r_dupx_ff ? '0 : rd_ff[{r_yp_ff, !r_xp_ff}];
      nb[2] = r_dupy_ff ? '0 : rd_ff[{!r_yp_ff, r_xp_ff}];
      nb[3] = (r_dupx_ff || r_dupy_ff) ? '0 : rd_ff[{!r_yp_ff, !r_xp_ff}];
      wx0 = $signed({1'b0, W_ONE - {1'b0, r_tx_ff}});
      wx1 = $signed({2'b00, r_tx_ff});
      sum_tmp[0] = lerp($signed(nb[0][ENTRY_BITS-1:0]), $signed(nb[1][ENTRY_BITS-1:0]),
                        wx0, wx1);
      sum_tmp[1] = lerp($signed(nb[2][ENTRY_BITS-1:0]), $signed(nb[3][ENTRY_BITS-1:0]),
                        wx0, wx1);
      sum_tmp[2] = lerp($signed(nb[0][2*ENTRY_BITS-1:ENTRY_BITS]),
                        $signed(nb[1][2*ENTRY_BITS-1:ENTRY_BITS]), wx0, wx1);
      sum_tmp[3] = lerp($signed(nb[2][2*ENTRY_BITS-1:ENTRY_BITS]),
                        $signed(nb[3][2*ENTRY_BITS-1:ENTRY_BITS]), wx0, wx1);
      ax_top_in = sum_tmp[0][A_BITS-1:0];
      ax_bot_in = sum_tmp[1][A_BITS-1:0];
      ay_top_in = sum_tmp[2][A_BITS-1:0];
      ay_bot_in = sum_tmp[3][A_BITS-1:0];
   end

   logic                     a_vld_ff;
   dgr_op_type               a_op_ff;
   logic [T_BITS-1:0]        a_ty_ff;
   logic signed [A_BITS-1:0] ax_top_ff, ax_bot_ff, ay_top_ff, ay_bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= r_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_op_ff   <= r_op_ff;
         a_ty_ff   <= r_ty_ff;
         ax_top_ff <= ax_top_in;
         ax_bot_ff <= ax_bot_in;
         ay_top_ff <= ay_top_in;
         ay_bot_ff <= ay_bot_in;
      end
   end

   // ---------------- interpolation along y
   logic signed [A_BITS+T_BITS+2:0] py0, py1, py2, py3;
   logic signed [S_BITS-1:0]        sx_in, sy_in;
   logic signed [A_BITS+T_BITS+2:0] sx_full, sy_full;

   always_comb begin
      wy0     = $signed({1'b0, W_ONE - {1'b0, a_ty_ff}});
      wy1     = $signed({2'b00, a_ty_ff});
      py0     = ax_top_ff * wy0;
      py1     = ax_bot_ff * wy1;
      py2     = ay_top_ff * wy0;
      py3     = ay_bot_ff * wy1;
      sx_full = py0 + py1;
      sy_full = py2 + py3;
      sx_in   = sx_full[S_BITS-1:0];
      sy_in   = sy_full[S_BITS-1:0];
   end

   logic                     s_vld_ff;
   dgr_op_type               s_op_ff;
   logic signed [S_BITS-1:0] sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (advance) begin
         s_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_op_ff <= a_op_ff;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
      end
   end

   // ---------------- range test, scaling and output register
   logic              in_x, in_y, coord_ok;
   logic [P_BITS-1:0] prod_x, prod_y;
   logic [V_BITS-1:0] vx, vy;
   logic [OUT_BITS-1:0] src_x_in, src_y_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] src_x_ff, src_y_ff;
   logic              coord_valid_ff;

   always_comb begin
      in_x     = !sx_ff[S_BITS-1] && ($unsigned(sx_ff) <= S_ONE);
      in_y     = !sy_ff[S_BITS-1] && ($unsigned(sy_ff) <= S_ONE);
      coord_ok = in_x && in_y;
      prod_x   = P_BITS'(sx_ff[ONE_POS:ENTRY_FRACTION_BITS]) * P_BITS'(width_m1);
      prod_y   = P_BITS'(sy_ff[ONE_POS:ENTRY_FRACTION_BITS]) * P_BITS'(height_m1);
      vx       = prod_x[P_BITS-1:P_BITS-V_BITS];
      vy       = prod_y[P_BITS-1:P_BITS-V_BITS];
      src_x_in = '0;
      src_y_in = '0;
      if (coord_ok) begin
         src_x_in = (vx > V_BITS'({OUT_BITS{1'b1}})) ? '1 : vx[OUT_BITS-1:0];
         src_y_in = (vy > V_BITS'({OUT_BITS{1'b1}})) ? '1 : vy[OUT_BITS-1:0];
      end
   end

   assign advance      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = advance ? (s_vld_ff && (s_op_ff == OP_PIXEL)) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         src_x_ff       <= src_x_in;
         src_y_ff       <= src_y_in;
         coord_valid_ff <= coord_ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_source_x    = src_x_ff;
   assign rsp_source_y    = src_y_ff;
   assign rsp_coord_valid = coord_valid_ff;

endmodule

### sv/distortion_grid_remap_generator_core.sv
// ----------------------------------------------------------------------------
// distortion_grid_remap_generator_core
// Bilinear distortion grid lookup that turns pixel items into source
// coordinates, with load items filling the grid.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* is a valid/ready channel. opcode load writes one grid entry and
//    gives no result; opcode pixel gives exactly one rsp_* item.
//  - rsp_* is a valid/ready channel carrying source_x, source_y and
//    coord_valid; results leave in request order.
//  - csr_* writes image_width (index 0) or image_height (index 1); write
//    only while no item is in flight.
//  - the path from request accept to rsp_valid runs through the queue, the
//    two 22-stage pipelined dividers (one quotient bit per stage), memory
//    read, two interpolation stages and the output register.
//  - throughput: one item per clock while no result is stalled; the divider
//    pipeline and banked grid memory (four neighbours read at once) carry it.
//  - when a result is held with rsp_ready low the back end freezes; a
//    four-entry queue keeps req_ready high until it fills.
//  - reset empties the queue and pipeline and sets the size registers to
//    640 x 240; grid entries are undefined until loaded.
// ----------------------------------------------------------------------------
module distortion_grid_remap_generator_core
   import dgr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [GRID_BITS-1:0]         req_grid_row,
   input  logic [GRID_BITS-1:0]         req_grid_col,
   input  logic signed [ENTRY_BITS-1:0] req_entry_x,
   input  logic signed [ENTRY_BITS-1:0] req_entry_y,
   input  logic [DIM_BITS-1:0]          req_pixel_x,
   input  logic [DIM_BITS-1:0]          req_pixel_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [OUT_BITS-1:0]          rsp_source_x,
   output logic [OUT_BITS-1:0]          rsp_source_y,
   output logic                         rsp_coord_valid,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [CFG_BITS-1:0]          csr_data
);

   logic [CFG_BITS-1:0]  width_ff, height_ff;
   logic [DIM_BITS-1:0]  width_m1, height_m1;
   dgr_item_type         head;
   dgr_queue_status_type status;
   logic                 pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_BITS'(640);
         height_ff <= CFG_BITS'(240);
      end else if (csr_write_enable) begin
         case (dgr_csr_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign width_m1  = size_m1(width_ff);
   assign height_m1 = size_m1(height_ff);

   dgr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_grid_row (req_grid_row),
      .req_grid_col (req_grid_col),
      .req_entry_x  (req_entry_x),
      .req_entry_y  (req_entry_y),
      .req_pixel_x  (req_pixel_x),
      .req_pixel_y  (req_pixel_y),
      .width_m1     (width_m1),
      .height_m1    (height_m1),
      .pop          (pop),
      .head         (head),
      .status       (status)
   );

   dgr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .status          (status),
      .pop             (pop),
      .width_m1        (width_m1),
      .height_m1       (height_m1),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_source_x    (rsp_source_x),
      .rsp_source_y    (rsp_source_y),
      .rsp_coord_valid (rsp_coord_valid)
   );

   // never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("queue popped while empty");

   // a stalled result freezes the back end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !pop)
      else $error("back end moved while result stalled");

   // invalid coordinates carry zero positions
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_coord_valid) |-> (rsp_source_x == '0 && rsp_source_y == '0))
      else $error("invalid coordinate with nonzero position");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
